// ===== sv/hmfg_pkg.sv =====
// ----------------------------------------------------------------------------
// hmfg_pkg
// Shared types and constants of the H-bridge motor fault guard.
// ----------------------------------------------------------------------------
package hmfg_pkg;

  localparam int unsigned MOTORS     = 4;
  localparam int unsigned MOTOR_W    = $clog2(MOTORS);
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned ENTRY_W    = 2 * TIME_W + COUNT_W;
  localparam int unsigned DUTY_W     = 13;
  localparam int unsigned MAG_W      = 16;

  localparam int unsigned DUTY_MAX_DEF   = 4199;
  localparam int unsigned SPEED_SPAN_DEF = 100;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_SPEED  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] FC_NONE        = 2'd0;
  localparam logic [1:0] FC_OVERCURRENT = 2'd1;
  localparam logic [1:0] FC_UNKNOWN     = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIDGE_MAP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS  = 2'd2;

  localparam logic [3:0]  REVERSE_MASK_RST = 4'd0;
  localparam logic [7:0]  BRIDGE_MAP_RST   = 8'd228;
  localparam logic [15:0] DEBOUNCE_MS_RST  = 16'd10;

  typedef struct packed {
    logic [TIME_W-1:0]  debounce_start;
    logic [TIME_W-1:0]  latch_time;
    logic [COUNT_W-1:0] latch_count;
  } entry_t;

endpackage

// ===== sv/hmfg_in_if.sv =====
// ----------------------------------------------------------------------------
// hmfg_in_if
// Command item channel: fault sample, set speed or clear faults.
// ----------------------------------------------------------------------------
interface hmfg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [2:0]         motor_id;
  logic               fault_active;
  logic signed [15:0] speed_cmd;
  logic [31:0]        now_ms;

  modport source (output valid, operation, motor_id, fault_active, speed_cmd, now_ms,
                  input ready);
  modport sink (input valid, operation, motor_id, fault_active, speed_cmd, now_ms,
                output ready);
endinterface

// ===== sv/hmfg_out_if.sv =====
// ----------------------------------------------------------------------------
// hmfg_out_if
// Result item channel: fault status and bridge duty update.
// ----------------------------------------------------------------------------
interface hmfg_out_if;
  logic        valid;
  logic        ready;
  logic        faulted;
  logic [1:0]  fault_code;
  logic [15:0] fault_total;
  logic [31:0] fault_time;
  logic        pwm_write;
  logic [1:0]  bridge;
  logic [12:0] duty_forward;
  logic [12:0] duty_reverse;

  modport source (output valid, faulted, fault_code, fault_total, fault_time, pwm_write,
                  bridge, duty_forward, duty_reverse, input ready);
  modport sink (input valid, faulted, fault_code, fault_total, fault_time, pwm_write,
                bridge, duty_forward, duty_reverse, output ready);
endinterface

// ===== sv/hmfg_ram.sv =====
// ----------------------------------------------------------------------------
// hmfg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmfg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/hbridge_motor_fault_guard_unit.sv =====
// ----------------------------------------------------------------------------
// hbridge_motor_fault_guard_unit
// Fault debounce/latch and duty generation for four motor H-bridges.
// ----------------------------------------------------------------------------
// Each item passes from acceptance to its result through a read of the motor's
// record from the state RAM, two multiply stages for the speed scaling
// (magnitude times DUTY_MAX, then a reciprocal multiply standing in for the
// divide by SPEED_SPAN) and a read-modify-write step that updates the record
// and loads the result register. Items are processed one at a time; the next
// item is taken in the cycle after the previous one has been written back.
// A result still waiting in the output register holds the next item in
// write-back, and with it the input. Per-motor pending and latched flags live
// in flops so that clear-faults drops all latches at once. There is no clearing
// pass after reset: each RAM entry has a valid flag and reads as zero until
// first written.
// ----------------------------------------------------------------------------
module hbridge_motor_fault_guard_unit #(
  parameter int unsigned DUTY_MAX   = hmfg_pkg::DUTY_MAX_DEF,
  parameter int unsigned SPEED_SPAN = hmfg_pkg::SPEED_SPAN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [hmfg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hmfg_pkg::CFG_DATA_W-1:0]     cfg_data,
  hmfg_in_if.sink                             req,
  hmfg_out_if.source                          rsp
);

  localparam int unsigned SPAN_LOG = $clog2(SPEED_SPAN);
  localparam int unsigned SHIFT    = 31 + SPAN_LOG;
  localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(SPEED_SPAN) - 64'd1) / 64'(SPEED_SPAN);
  localparam logic [31:0] RECIP    = RECIP_WIDE[31:0];

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_WB   = 3'd4;

  logic [2:0] state, state_next;

  logic [3:0]  reverse_mask;
  logic [7:0]  bridge_map;
  logic [15:0] debounce_ms;

  logic [hmfg_pkg::MOTORS-1:0] pending, pending_next;
  logic [hmfg_pkg::MOTORS-1:0] latched, latched_next;
  logic [hmfg_pkg::MOTORS-1:0] entry_ok;

  logic [1:0]  op_q;
  logic [2:0]  mid_q;
  logic        pin_q;
  logic [15:0] speed_q;
  logic [31:0] now_q;

  logic        sat_q;
  logic        neg_q;
  logic [31:0] prod1;
  logic [63:0] prod2;

  logic                           mvalid;
  logic [hmfg_pkg::MOTOR_W-1:0]   k;
  logic [1:0]                     br;
  logic [15:0]                    mag_abs;
  logic [hmfg_pkg::MAG_W-1:0]     quo;
  logic [hmfg_pkg::MAG_W-1:0]     mag;

  hmfg_pkg::entry_t ram_rdata_raw, ent, ent_next;
  logic             ram_we;
  logic             wb_go;
  logic [31:0]      elapsed;

  logic        wr;
  logic [12:0] dfw, drv;

  hmfg_ram #(
    .WIDTH(hmfg_pkg::ENTRY_W),
    .DEPTH(hmfg_pkg::MOTORS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(k),
    .wdata(ent_next),
    .raddr(k),
    .rdata(ram_rdata_raw)
  );

  assign req.ready = (state == ST_IDLE);
  assign mvalid    = (mid_q >= 3'd1) && (mid_q <= 3'd4);
  assign k         = mvalid ? 2'(mid_q - 3'd1) : '0;
  assign br        = mvalid ? bridge_map[{k, 1'b0} +: 2] : 2'd0;
  assign wb_go     = (state == ST_WB) && (!rsp.valid || rsp.ready);
  assign ram_we    = wb_go && mvalid && (op_q == hmfg_pkg::OP_SAMPLE);
  assign ent       = entry_ok[k] ? ram_rdata_raw : '0;
  assign elapsed   = now_q - ent.debounce_start;
  assign mag_abs   = speed_q[15] ? 16'(~speed_q + 16'd1) : speed_q;
  assign quo       = prod2[SHIFT +: hmfg_pkg::MAG_W];
  assign mag       = sat_q ? hmfg_pkg::MAG_W'(DUTY_MAX) : quo;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req.valid) state_next = ST_RD;
      ST_RD:   state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_WB;
      ST_WB:   if (wb_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pending_next = pending;
    latched_next = latched;
    ent_next     = ent;
    wr           = 1'b0;
    dfw          = '0;
    drv          = '0;
    case (op_q)
      hmfg_pkg::OP_CLEAR: begin
        latched_next = '0;
      end
      hmfg_pkg::OP_SAMPLE: begin
        if (mvalid) begin
          if (pin_q) begin
            if (!pending[k]) begin
              pending_next[k]         = 1'b1;
              ent_next.debounce_start = now_q;
            end else if (elapsed >= {16'd0, debounce_ms} && !latched[k]) begin
              latched_next[k]      = 1'b1;
              ent_next.latch_time  = now_q;
              ent_next.latch_count = ent.latch_count + 16'd1;
              wr                   = 1'b1;
            end
          end else begin
            pending_next[k] = 1'b0;
            latched_next[k] = 1'b0;
          end
        end
      end
      hmfg_pkg::OP_SPEED: begin
        if (mvalid) begin
          wr = 1'b1;
          if (!latched[k]) begin
            if (neg_q) drv = mag[12:0];
            else dfw = mag[12:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_mask <= hmfg_pkg::REVERSE_MASK_RST;
      bridge_map   <= hmfg_pkg::BRIDGE_MAP_RST;
      debounce_ms  <= hmfg_pkg::DEBOUNCE_MS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hmfg_pkg::REG_REVERSE_MASK: reverse_mask <= cfg_data[3:0];
        hmfg_pkg::REG_BRIDGE_MAP:   bridge_map   <= cfg_data[7:0];
        hmfg_pkg::REG_DEBOUNCE_MS:  debounce_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= '0;
      latched   <= '0;
      entry_ok  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wb_go) begin
        pending   <= pending_next;
        latched   <= latched_next;
        rsp.valid <= 1'b1;
        if (ram_we) entry_ok[k] <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q    <= req.operation;
      mid_q   <= req.motor_id;
      pin_q   <= req.fault_active;
      speed_q <= req.speed_cmd;
      now_q   <= req.now_ms;
    end
    if (state == ST_MUL1) begin
      sat_q <= mag_abs >= 16'(SPEED_SPAN);
      neg_q <= speed_q[15] ^ reverse_mask[k];
      prod1 <= 32'(mag_abs) * 32'(DUTY_MAX);
    end
    if (state == ST_MUL2) begin
      prod2 <= 64'(prod1) * 64'(RECIP);
    end
    if (wb_go) begin
      rsp.faulted      <= mvalid && latched_next[k];
      rsp.fault_code   <= !mvalid ? hmfg_pkg::FC_UNKNOWN :
                          latched_next[k] ? hmfg_pkg::FC_OVERCURRENT : hmfg_pkg::FC_NONE;
      rsp.fault_total  <= mvalid ? ent_next.latch_count : '0;
      rsp.fault_time   <= mvalid ? ent_next.latch_time : '0;
      rsp.pwm_write    <= wr;
      rsp.bridge       <= br;
      rsp.duty_forward <= dfw;
      rsp.duty_reverse <= drv;
    end
  end

  a_ram_write_in_wb: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_WB)
    else $error("state RAM written outside write-back");

  a_accept_starts_read: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == ST_RD)
    else $error("accepted item did not start a RAM read");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.duty_forward == 13'd0 || rsp.duty_reverse == 13'd0))
    else $error("both bridge channels driven");

  a_unknown_motor_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.fault_code == hmfg_pkg::FC_UNKNOWN) |-> (!rsp.faulted && !rsp.pwm_write))
    else $error("invalid motor reported fault or duty write");

endmodule
